>>> hw/rtl/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the max priority queue and its cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DATA_W = 32;

  // Request operation codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert that fits
    logic ext;  // extract from a non-empty queue
  } mpq_cmd_t;

endpackage

>>> hw/rtl/mpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted row. Holds one value; the row is kept in
// descending order from slot 0, occupied slots below the fill count.
// ----------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  mpq_cmd_t                 cmd,
  input  logic [CNT_W-1:0]         fill_count,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     gt
);

  localparam logic [CNT_W-1:0] SLOT = CNT_W'(IDX);

  logic signed [DATA_W-1:0] data_next;

  // new value beats this slot when the slot is free or holds less
  always_comb begin
    gt = (fill_count <= SLOT) || (value > data);
  end

  // insert: shift right from the first losing slot; extract: shift left
  always_comb begin
    data_next = data;
    priority if (cmd.ins) begin
      if (left_gt) begin
        data_next = left_data;
      end else if (gt) begin
        data_next = value;
      end
    end else if (cmd.ext) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hw/rtl/max_priority_queue.sv
`timescale 1ns / 1ps
// Response: registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle; every cell updates in parallel, so the
// rate does not depend on CAPACITY. A stalled response holds off new requests.
// Reset: synchronous, clears the fill count and response valid; slot contents
// are not cleared and are never read before written.
// ----------------------------------------------------------------------------
// max_priority_queue
// Fixed-capacity max priority queue of signed 32-bit values, built as a row
// of cells kept sorted in descending order. Insert or extract-max per request.
// ----------------------------------------------------------------------------
module max_priority_queue
  import mpq_pkg::*;
#(
  parameter int  CAPACITY = 64,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     func,
  input  logic signed [DATA_W-1:0] value,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] max_value,
  output logic                     got_value,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]         fill_count;
  logic [CNT_W-1:0]         fill_count_next;
  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  mpq_cmd_t                 cmd;
  status_t                  st;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic                     cell_gt   [CAPACITY];

  // Request handshake: one response register between the two sides
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign is_full  = (fill_count == FULL_CNT);
  assign is_empty = (fill_count == '0);

  // Decode the request into a cell command and a status
  always_comb begin
    cmd.ins = accept && (func == FUNC_INSERT) && !is_full;
    cmd.ext = accept && (func == FUNC_EXTRACT) && !is_empty;
    unique case (func)
      FUNC_INSERT:  st = is_full ? ST_FULL : ST_OK;
      FUNC_EXTRACT: st = is_empty ? ST_EMPTY : ST_OK;
      default:      st = ST_OK;
    endcase
  end

  // Fill count update
  always_comb begin
    fill_count_next = fill_count;
    if (cmd.ins) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (cmd.ext) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  // Row of cells, slot 0 holds the maximum
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] ldata;
    logic                     lgt;
    logic signed [DATA_W-1:0] rdata;

    if (i == 0) begin : g_head
      assign ldata = '0;
      assign lgt   = 1'b0;
    end else begin : g_body
      assign ldata = cell_data[i-1];
      assign lgt   = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rdata = '0;
    end else begin : g_link
      assign rdata = cell_data[i+1];
    end

    mpq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .fill_count (fill_count),
      .value      (value),
      .left_data  (ldata),
      .left_gt    (lgt),
      .right_data (rdata),
      .data       (cell_data[i]),
      .gt         (cell_gt[i])
    );
  end

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      max_value <= cmd.ext ? cell_data[0] : '0;
      got_value <= cmd.ext;
      status    <= st;
      count     <= fill_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_CNT)
    else $error("fill count above capacity");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request produced no response");

  a_got_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && got_value) |-> (status == ST_OK))
    else $error("returned value with error status");

  a_ext_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ext |=> (fill_count == $past(fill_count) - CNT_W'(1)))
    else $error("extract did not decrement count");
`endif

endmodule

>>> verif/max_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_test
// Self-checking bench for the max priority queue. A short directed list
// covers empty and extreme values, ties and an extract that carries data,
// then random insert/extract phases drive the queue full and empty
// repeatedly. Every response is checked against a behavioral queue model,
// with random request gaps, random response stalls and one long hold-off.
// ----------------------------------------------------------------------------
module max_priority_queue_test;
  import mpq_pkg::*;

  localparam int QUEUE_DEPTH   = 64;
  localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_REQS    = 850;
  localparam int LONG_HOLD     = 200;
  localparam int HOLD_AFTER    = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int DIRECTED_ROWS = 23;

  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic                     got_value;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } response_t;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] operand;
    logic                     typed;   // response below is known up front
    response_t                resp;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic                     func = FUNC_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [DATA_W-1:0] max_value;
  logic                     got_value;
  logic [1:0]               status;
  logic [COUNT_W-1:0]       count;

  // Model contents, kept unordered; extract scans for the largest
  logic signed [DATA_W-1:0] model_contents[$];
  response_t                pending_responses[$];

  int  errors = 0;
  int  requests_accepted = 0;
  int  responses_checked = 0;
  int  dropped_full = 0;
  int  extract_empty = 0;
  int  extract_hits = 0;
  int  burst_left = 0;
  bit  long_hold_done = 1'b0;

  // Empty, extremes, duplicates, ties and don't-care value on extract
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_EXTRACT, 32'sh00000000, 1'b1, '{32'sh0, 1'b0, ST_EMPTY, 7'd0}},
    '{FUNC_INSERT,  32'sh7fffffff, 1'b1, '{32'sh0, 1'b0, ST_OK,    7'd1}},
    '{FUNC_INSERT,  32'sh80000000, 1'b1, '{32'sh0, 1'b0, ST_OK,    7'd2}},
    '{FUNC_INSERT,  32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_INSERT,  32'shffffffff, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_INSERT,  32'sh00000001, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_INSERT,  32'sh00000005, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_INSERT,  32'sh00000005, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_INSERT,  32'sh80000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b1, '{32'sh7fffffff, 1'b1, ST_OK, 7'd7}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh12345678, 1'b1, '{32'sh0, 1'b0, ST_EMPTY, 7'd0}},
    '{FUNC_INSERT,  32'shaaaaaaaa, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_INSERT,  32'sh55555555, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'shffffffff, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b0, '{32'sh0, 1'b0, ST_OK,    7'd0}},
    '{FUNC_EXTRACT, 32'sh00000000, 1'b1, '{32'sh0, 1'b0, ST_EMPTY, 7'd0}}
  };

  max_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func     (func),
    .value    (value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .max_value(max_value),
    .got_value(got_value),
    .status   (status),
    .count    (count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue model: apply one request and return the response it should give
  function automatic response_t predict_queue_op(logic op, logic signed [DATA_W-1:0] operand);
    response_t r;
    int        top_idx;
    r = '{'0, 1'b0, ST_OK, '0};
    if (op == FUNC_INSERT) begin
      if (model_contents.size() >= QUEUE_DEPTH) r.status = ST_FULL;
      else model_contents.push_back(operand);
    end else if (model_contents.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      top_idx = 0;
      foreach (model_contents[i])
        if (model_contents[i] > model_contents[top_idx]) top_idx = i;
      r.max_value = model_contents[top_idx];
      r.got_value = 1'b1;
      model_contents.delete(top_idx);
    end
    r.count = COUNT_W'(model_contents.size());
    return r;
  endfunction

  // Present one request, hold it until taken, record its response, then
  // maybe open a gap before the next burst
  task automatic offer_request(logic op, logic signed [DATA_W-1:0] operand,
                               logic typed, response_t typed_resp);
    response_t predicted;
    req_valid <= 1'b1;
    func      <= op;
    value     <= operand;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_queue_op(op, operand);
    if (typed) predicted = typed_resp;
    pending_responses.push_back(predicted);
    requests_accepted++;
    if (predicted.status == ST_FULL) dropped_full++;
    if (predicted.status == ST_EMPTY) extract_empty++;
    if (predicted.got_value) extract_hits++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 25);
      if ($urandom_range(2) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Response checker
  always @(posedge clk) begin
    response_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding: max_value=%0d count=%0d",
               max_value, count);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        if (max_value !== want.max_value) begin
          $error("max_value: expected %0d, got %0d", want.max_value, max_value);
          errors++;
        end
        if (got_value !== want.got_value) begin
          $error("got_value: expected %0b, got %0b", want.got_value, got_value);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d responses still outstanding", pending_responses.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Response stall pattern, with one long hold-off mid-run
  initial begin
    int mode;
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && requests_accepted >= HOLD_AFTER) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        mode = $urandom_range(2);
        span = $urandom_range(10, 80);
        for (int k = 0; k < span; k++) begin
          case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(2) == 0);
            default: rsp_stall <= k[0];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int                       insert_pct;
    int                       phase_left;
    logic                     op;
    logic signed [DATA_W-1:0] operand;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].op, directed_rows[i].operand,
                    directed_rows[i].typed, directed_rows[i].resp);

    // Random phases; the first one is insert-heavy so the queue fills early
    insert_pct = 90;
    phase_left = 110;
    while (requests_accepted < TOTAL_REQS) begin
      if (phase_left == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 90;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
        phase_left = $urandom_range(20, 100);
      end
      phase_left--;
      op = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
      case ($urandom_range(9))
        0: operand = 32'sh7fffffff;
        1: operand = 32'sh80000000;
        2, 3: operand = DATA_W'($signed($urandom_range(8)) - 4);
        default: operand = $urandom;
      endcase
      offer_request(op, operand, 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests, checked %0d responses", requests_accepted, responses_checked);
    $display("  %0d values extracted, %0d inserts dropped full, %0d extracts on empty",
             extract_hits, dropped_full, extract_empty);
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_cell.sv
hw/rtl/max_priority_queue.sv
verif/max_priority_queue_test.sv
